/* hdl/wtas_pkg.sv */
// Shared constants, types and helpers of the weighted tree add-and-select unit.
package wtas_pkg;

	// Tree sizing
	localparam int MAX_POSITIONS = 1024;
	localparam int NODE_COUNT    = 4096;
	localparam int CFG_RESET     = 1024;

	// Field and storage widths
	localparam int POS_W    = $clog2(MAX_POSITIONS + 1);
	localparam int KEY_W    = 31;
	localparam int SUM_W    = 32;
	localparam int NODE_W   = $clog2(NODE_COUNT);
	localparam int TREE_W   = $clog2(4 * MAX_POSITIONS);
	localparam int IDX_W    = (TREE_W > NODE_W) ? TREE_W : NODE_W;
	localparam int LEVEL_CNT = $clog2(MAX_POSITIONS);
	// Remaining target: key plus or minus one sum per level, never wraps
	localparam int REM_W    = SUM_W + 1 + $clog2(LEVEL_CNT + 1);

	// Command codes
	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_SELECT = 1'b1;

	// Walker states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_SEL_RD,
		ST_SEL_CHK,
		ST_SEL_OUT
	} walk_state_t;

	// Node memory access from the walker
	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		logic [SUM_W-1:0]  wdata;
		logic              re;
		logic [NODE_W-1:0] raddr;
	} mem_req_t;

	// Select result handed to the output register
	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] position;
	} res_t;

	// True when a node index has storage behind it
	function automatic logic node_ok(input logic [IDX_W-1:0] u);
		node_ok = ({1'b0, u} < (IDX_W + 1)'(NODE_COUNT));
	endfunction

endpackage

/* hdl/wtas_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module wtas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/wtas_walker.sv */
// Tree walker: clearing pass, add path read-modify-write and select descent.
module wtas_walker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           cmd,
	input  logic [wtas_pkg::KEY_W-1:0]     key,
	input  logic [wtas_pkg::SUM_W-1:0]     amount,
	input  logic [wtas_pkg::POS_W-1:0]     leaf_cnt,
	output logic                           ready,
	output wtas_pkg::mem_req_t             mem_req,
	input  logic [wtas_pkg::SUM_W-1:0]     mem_rdata,
	output wtas_pkg::res_t                 res,
	input  logic                           res_ready
);
	import wtas_pkg::*;

	walk_state_t             state_q, state_d;
	logic [NODE_W-1:0]       clr_q;
	logic [IDX_W-1:0]        u_q;
	logic [POS_W-1:0]        l_q, r_q, key_q;
	logic [SUM_W-1:0]        amt_q;
	logic signed [REM_W-1:0] rem_q;
	logic                    rd_ok_s1;

	logic [POS_W:0]          lr_sum;
	logic [POS_W-1:0]        mid;
	logic                    leaf;
	logic [IDX_W-1:0]        u_left, u_right;
	logic [SUM_W-1:0]        rd_sum;
	logic signed [REM_W-1:0] rs_ext;
	logic                    go_right;
	logic                    key_ok;

	// Split point, leaf test and child indexes
	assign lr_sum   = {1'b0, l_q} + {1'b0, r_q};
	assign mid      = lr_sum[POS_W:1];
	assign leaf     = (({1'b0, l_q} + (POS_W + 1)'(1)) == {1'b0, r_q});
	assign u_left   = {u_q[IDX_W-2:0], 1'b0};
	assign u_right  = {u_q[IDX_W-2:0], 1'b1};

	// Nodes without storage read as zero
	assign rd_sum   = rd_ok_s1 ? mem_rdata : '0;
	assign rs_ext   = $signed({{(REM_W - SUM_W){rd_sum[SUM_W-1]}}, rd_sum});
	assign go_right = (rs_ext >= rem_q);

	// Add position must lie in 1..n
	assign key_ok   = (key != '0) && (key <= KEY_W'(leaf_cnt));

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + NODE_W'(1);
			end
		end
	end

	// Next state, memory requests and result
	always_comb begin
		state_d         = state_q;
		mem_req         = '0;
		ready           = 1'b0;
		res.valid       = 1'b0;
		res.position    = l_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_q;
				mem_req.wdata = '0;
				if (clr_q == NODE_W'(NODE_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				ready = 1'b1;
				if (start) begin
					if (cmd == CMD_SELECT) begin
						state_d = ST_SEL_RD;
					end else if (key_ok) begin
						state_d = ST_ADD_RD;
					end
				end
			end
			ST_ADD_RD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = u_q[NODE_W-1:0];
				state_d       = ST_ADD_WR;
			end
			ST_ADD_WR: begin
				mem_req.we    = node_ok(u_q);
				mem_req.waddr = u_q[NODE_W-1:0];
				mem_req.wdata = rd_sum + amt_q;
				state_d       = leaf ? ST_IDLE : ST_ADD_RD;
			end
			ST_SEL_RD: begin
				if (leaf) begin
					state_d = ST_SEL_OUT;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = u_right[NODE_W-1:0];
					state_d       = ST_SEL_CHK;
				end
			end
			ST_SEL_CHK: begin
				state_d = ST_SEL_RD;
			end
			ST_SEL_OUT: begin
				res.valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Walk registers: load on a transaction, advance one level per step
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					u_q   <= IDX_W'(1);
					l_q   <= POS_W'(1);
					r_q   <= leaf_cnt + POS_W'(1);
					key_q <= key[POS_W-1:0];
					amt_q <= amount;
					rem_q <= $signed({{(REM_W - KEY_W){1'b0}}, key});
				end
			end
			ST_ADD_RD: begin
				rd_ok_s1 <= node_ok(u_q);
			end
			ST_ADD_WR: begin
				if (!leaf) begin
					if (key_q < mid) begin
						u_q <= u_left;
						r_q <= mid;
					end else begin
						u_q <= u_right;
						l_q <= mid;
					end
				end
			end
			ST_SEL_RD: begin
				rd_ok_s1 <= node_ok(u_right);
			end
			ST_SEL_CHK: begin
				if (go_right) begin
					u_q <= u_right;
					l_q <= mid;
				end else begin
					rem_q <= rem_q - rs_ext;
					u_q   <= u_left;
					r_q   <= mid;
				end
			end
			default: begin
			end
		endcase
	end

	// No transaction is taken while the clearing pass runs
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !ready)
		else $error("walker ready during clearing pass");

	// A select decision always uses data read in the cycle before
	a_chk_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEL_CHK) |-> $past(mem_req.re))
		else $error("select compare without a preceding read");

	// The active range never empties during a walk
	a_range_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD_WR || state_q == ST_SEL_RD || state_q == ST_SEL_OUT)
		|-> (l_q < r_q))
		else $error("walk range collapsed");

endmodule

/* hdl/weighted_tree_add_and_select_unit.sv */
// Weighted tree add-and-select unit: a segment tree of 32-bit node sums held in
// one synchronous RAM. An add transaction updates every node sum on the path to
// one position. A select transaction descends from the root and hands its result
// to the output register, a hand-over that stretches while the output register is
// still full. Each level of the path, at most ceil(log2(n)) deep, costs one RAM
// read, whose registered data feeds the add or compare that uses it. After reset
// a clearing pass zeroes all 4096 nodes, during which no transaction is taken;
// configuration writes are taken at any time. An add with a position of 0 or
// above n changes nothing and produces no result.
module weighted_tree_add_and_select_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wtas_pkg::POS_W-1:0]          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd,
	input  logic [wtas_pkg::KEY_W-1:0]          key,
	input  logic signed [wtas_pkg::SUM_W-1:0]   amount,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [wtas_pkg::POS_W-1:0]          found_position
);
	import wtas_pkg::*;

	logic [POS_W-1:0] pos_cfg_q;
	logic [POS_W-1:0] leaf_cnt;
	logic             walk_ready;
	mem_req_t         mem_req;
	logic [SUM_W-1:0] mem_rdata;
	res_t             res;
	logic             res_ready;
	logic             out_valid_q;
	logic [POS_W-1:0] out_pos_q;

	// Leaf count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_cfg_q <= POS_W'(CFG_RESET);
		end else if (cfg_we) begin
			pos_cfg_q <= cfg_wdata;
		end
	end

	// Clamp the leaf count to 1..MAX_POSITIONS
	always_comb begin
		if (pos_cfg_q == '0) begin
			leaf_cnt = POS_W'(1);
		end else if (pos_cfg_q > POS_W'(MAX_POSITIONS)) begin
			leaf_cnt = POS_W'(MAX_POSITIONS);
		end else begin
			leaf_cnt = pos_cfg_q;
		end
	end

	assign in_ready = walk_ready;

	wtas_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid & walk_ready),
		.cmd       (cmd),
		.key       (key),
		.amount    (amount),
		.leaf_cnt  (leaf_cnt),
		.ready     (walk_ready),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res       (res),
		.res_ready (res_ready)
	);

	wtas_ram #(
		.WIDTH (SUM_W),
		.DEPTH (NODE_COUNT)
	) u_node_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	// Output register: hold until taken, refill in the same cycle
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_pos_q <= res.position;
		end
	end

	assign out_valid      = out_valid_q;
	assign found_position = out_pos_q;

	// A reported position always lies within 1..MAX_POSITIONS
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_pos_q != '0 && out_pos_q <= POS_W'(MAX_POSITIONS)))
		else $error("found position out of range");

endmodule

/* verif/weighted_tree_add_and_select_unit_tb.sv */
// Self-checking testbench for the weighted tree add-and-select unit.
`timescale 1ns / 100ps

module weighted_tree_add_and_select_unit_tb;

	import wtas_pkg::*;

	localparam int HOLD_CYCLES        = 600;
	localparam int SETTLE_CYCLES      = 48;
	localparam int DRAIN_LIMIT        = 10000;
	localparam int WATCHDOG_LIMIT     = 20000;
	localparam int RANDOM_BLOCK_ITEMS = 112;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [POS_W-1:0]        cfg_wdata = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic                    cmd       = CMD_ADD;
	logic [KEY_W-1:0]        key       = '0;
	logic signed [SUM_W-1:0] amount    = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [POS_W-1:0]        found_position;

	// Predicted tree state and leaf count register
	logic [SUM_W-1:0] tree_sum [0:NODE_COUNT-1];
	int unsigned      leaves_cfg = CFG_RESET;
	logic [POS_W-1:0] expected_positions [$];

	int error_count    = 0;
	int idle_cycles    = 0;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int hold_id        = 0;
	int hold_seen      = 0;
	int hold_left      = 0;

	weighted_tree_add_and_select_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.key            (key),
		.amount         (amount),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.found_position (found_position)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Clamp the register value to the leaf count the tree actually uses
	function automatic int unsigned active_leaves();
		int unsigned n;
		n = leaves_cfg;
		if (n == 0) n = 1;
		if (n > MAX_POSITIONS) n = MAX_POSITIONS;
		return n;
	endfunction

	// Add a weight along the root-to-leaf path; ignore positions outside 1..n
	task automatic tree_add(input logic [KEY_W-1:0] pos, input logic [SUM_W-1:0] amt);
		int unsigned n, lo, hi, mid, node;
		n = active_leaves();
		lo = 1;
		hi = n + 1;
		node = 1;
		if (pos < 1 || pos > n) return;
		while (lo + 1 != hi) begin
			if (node < NODE_COUNT) tree_sum[node] += amt;
			mid = (lo + hi) >> 1;
			if (pos < mid) begin
				node = node * 2;
				hi = mid;
			end else begin
				node = node * 2 + 1;
				lo = mid;
			end
		end
		if (node < NODE_COUNT) tree_sum[node] += amt;
	endtask

	// Descend from the root: go right while the right sum covers the target
	function automatic logic [POS_W-1:0] tree_select(input logic [KEY_W-1:0] target);
		int unsigned n, lo, hi, mid, node;
		longint remaining, right_sum;
		n = active_leaves();
		lo = 1;
		hi = n + 1;
		node = 1;
		remaining = longint'({1'b0, target});
		while (lo + 1 != hi) begin
			right_sum = 0;
			if (node * 2 + 1 < NODE_COUNT) right_sum = longint'($signed(tree_sum[node * 2 + 1]));
			mid = (lo + hi) >> 1;
			if (right_sum >= remaining) begin
				node = node * 2 + 1;
				lo = mid;
			end else begin
				remaining -= right_sum;
				node = node * 2;
				hi = mid;
			end
		end
		return POS_W'(lo);
	endfunction

	// Track config writes and input transactions, check each output transaction
	always @(posedge clk) begin : result_check
		logic [POS_W-1:0] want;
		if (arst_n) begin
			if (cfg_we) leaves_cfg = cfg_wdata;
			if (in_valid && in_ready) begin
				if (cmd == CMD_SELECT) expected_positions.push_back(tree_select(key));
				else tree_add(key, amount);
			end
			if (out_valid && out_ready) begin
				if (expected_positions.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual found_position %0d",
						$time, found_position);
					error_count++;
				end else begin
					want = expected_positions.pop_front();
					if (found_position !== want) begin
						$display("%0t: found_position mismatch, expected %0d, actual %0d",
							$time, want, found_position);
						error_count++;
					end
				end
			end
		end
	end

	// Drive out_ready: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_id != hold_seen) begin
			hold_seen = hold_id;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// End the run when no transaction of any kind moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Offer one item after a random gap and hold it until accepted
	task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
		input logic [SUM_W-1:0] amt);
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct) gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		key      <= k;
		amount   <= amt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stop offering and wait for every pending result
	task automatic drain_results();
		int waited;
		in_valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (expected_positions.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
	endtask

	// Drain, then give a trailing add time to finish its walk
	task automatic settle_idle();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [POS_W-1:0] value);
		settle_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Mostly in-range adds and selects aimed at the total weight, some noise
	task automatic send_random_item();
		int unsigned n, roll;
		logic [SUM_W-1:0] amt;
		logic [KEY_W-1:0] target;
		longint root;
		n = active_leaves();
		roll = $urandom_range(99);
		amt = $urandom_range(2000) - 500;
		if ($urandom_range(9) == 0) amt = $urandom();
		root = longint'($signed(tree_sum[1]));
		if (roll < 44) begin
			send_item(CMD_ADD, KEY_W'($urandom_range(n, 1)), amt);
		end else if (roll < 80) begin
			if (root > 0 && $urandom_range(4) != 0) target = KEY_W'($urandom_range(32'(root + 2)));
			else target = KEY_W'($urandom_range(3));
			send_item(CMD_SELECT, target, $urandom());
		end else if (roll < 88) begin
			case ($urandom_range(2))
				0: target = '0;
				1: target = KEY_W'(n + 1);
				default: target = KEY_W'($urandom());
			endcase
			send_item(CMD_ADD, target, $urandom());
		end else begin
			send_item(CMD_SELECT, KEY_W'($urandom()), $urandom());
		end
	endtask

	// Empty tree at the reset leaf count, plus ignored out-of-range adds
	task automatic test_empty_tree();
		send_item(CMD_SELECT, KEY_W'(0), 32'h0);
		send_item(CMD_SELECT, KEY_W'(1), 32'hFFFF_FFFF);
		send_item(CMD_SELECT, KEY_W'(31'h7FFF_FFFF), 32'h0);
		send_item(CMD_ADD, KEY_W'(0), 32'h0000_1234);
		send_item(CMD_ADD, KEY_W'(MAX_POSITIONS + 1), 32'h0000_0042);
		send_item(CMD_ADD, KEY_W'(31'h7FFF_FFFF), 32'hFFFF_FFFF);
		send_item(CMD_SELECT, KEY_W'(0), 32'h0);
	endtask

	// Largest positive and negative weights at both ends, including wraparound
	task automatic test_extreme_weights();
		send_item(CMD_ADD, KEY_W'(1), 32'h7FFF_FFFF);
		send_item(CMD_ADD, KEY_W'(MAX_POSITIONS), 32'h8000_0000);
		send_item(CMD_ADD, KEY_W'(MAX_POSITIONS / 2), 32'h0000_0001);
		send_item(CMD_SELECT, KEY_W'(31'h7FFF_FFFF), 32'h0);
		send_item(CMD_SELECT, KEY_W'(1), 32'h0);
		send_item(CMD_SELECT, KEY_W'(0), 32'h0);
		send_item(CMD_ADD, KEY_W'(MAX_POSITIONS), 32'h8000_0000);
	endtask

	// Single leaf, zero and oversized leaf counts, and the two-leaf tree
	task automatic test_leaf_count_limits();
		write_config(POS_W'(1));
		send_item(CMD_SELECT, KEY_W'(100), 32'h0);
		send_item(CMD_ADD, KEY_W'(1), 32'h0000_0005);
		send_item(CMD_ADD, KEY_W'(2), 32'h0000_0009);
		send_item(CMD_SELECT, KEY_W'(0), 32'h0);
		write_config(POS_W'(0));
		send_item(CMD_SELECT, KEY_W'(0), 32'h0);
		send_item(CMD_ADD, KEY_W'(1), 32'hFFFF_FFFD);
		write_config(POS_W'(2047));
		send_item(CMD_SELECT, KEY_W'(0), 32'h0);
		send_item(CMD_ADD, KEY_W'(MAX_POSITIONS), 32'h0000_0003);
		send_item(CMD_SELECT, KEY_W'(3), 32'h0);
		write_config(POS_W'(2));
		send_item(CMD_SELECT, KEY_W'(0), 32'h0);
		send_item(CMD_SELECT, KEY_W'(1), 32'h0);
	endtask

	// Hold off the output so the unit fills and stalls its input, then pause
	task automatic test_input_backpressure();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		drain_results();
		hold_id++;
		repeat (6) send_item(CMD_SELECT, KEY_W'($urandom()), $urandom());
		repeat (20) send_random_item();
		drain_results();
		repeat (10) send_random_item();
	endtask

	// Random traffic over several leaf counts and idling phases
	task automatic test_random_traffic();
		logic [POS_W-1:0] size;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct   = 48;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 48;
				end
				default: begin
					src_idle_pct   = 35;
					sink_stall_pct = 35;
				end
			endcase
			for (int s = 0; s < 4; s++) begin
				case (ph * 4 + s)
					0:  size = POS_W'(1024);
					1:  size = POS_W'(3);
					2:  size = POS_W'(1000);
					3:  size = POS_W'(1);
					4:  size = POS_W'(2047);
					5:  size = POS_W'(513);
					6:  size = POS_W'(0);
					8:  size = POS_W'(1025);
					9:  size = POS_W'(2);
					10: size = POS_W'(1023);
					12: size = POS_W'(64);
					14: size = POS_W'(5);
					15: size = POS_W'(1024);
					default: size = POS_W'($urandom_range(MAX_POSITIONS, 1));
				endcase
				write_config(size);
				repeat (RANDOM_BLOCK_ITEMS) send_random_item();
			end
		end
	endtask

	initial begin
		foreach (tree_sum[i]) tree_sum[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_tree();
		test_extreme_weights();
		test_leaf_count_limits();
		test_input_backpressure();
		test_random_traffic();
		settle_idle();
		if (expected_positions.size() != 0) begin
			$display("%0t: %0d expected results never arrived, actual none",
				$time, expected_positions.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
